// ----- sv/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the pressure and temperature compensation
// pipeline: calibration register indexes, reset values and status codes.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W    = 24;
    localparam int CAL_W    = 16;
    localparam int LIMIT_W  = 18;
    localparam int CFG_IDX_W = 3;
    localparam int TEMP_OUT_W = 15;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TCO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TCO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI    = 3'd7;

    localparam logic [LIMIT_W-1:0] PRESS_LO_RESET = 18'd1000;
    localparam logic [LIMIT_W-1:0] PRESS_HI_RESET = 18'd120000;

    // Temperature limits in 0.01 C.
    localparam int TEMP_LOW_LIMIT  = -4000;
    localparam int TEMP_HIGH_LIMIT = 8500;

    // Result status codes.
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_LOW  = 2'd1;
    localparam logic [1:0] STAT_HIGH = 2'd2;

    typedef struct packed {
        logic [CAL_W-1:0]   c1;     // pressure sensitivity
        logic [CAL_W-1:0]   c2;     // pressure offset
        logic [CAL_W-1:0]   c3;     // temperature coefficient of sensitivity
        logic [CAL_W-1:0]   c4;     // temperature coefficient of offset
        logic [CAL_W-1:0]   c5;     // reference temperature
        logic [CAL_W-1:0]   c6;     // temperature coefficient of temperature
        logic [LIMIT_W-1:0] p_lo;
        logic [LIMIT_W-1:0] p_hi;
    } t_ptc_cal;

endpackage

// ----- sv/ptc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ptc_cfg_regs
// Calibration and limit register file, written through a plain write port.
// Bits above a register's width are dropped.
// ----------------------------------------------------------------------------
module ptc_cfg_regs
    import ptc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    output t_ptc_cal             o_cal
);

    t_ptc_cal r_cal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.c1   <= '0;
            r_cal.c2   <= '0;
            r_cal.c3   <= '0;
            r_cal.c4   <= '0;
            r_cal.c5   <= '0;
            r_cal.c6   <= '0;
            r_cal.p_lo <= PRESS_LO_RESET;
            r_cal.p_hi <= PRESS_HI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PRESS_SENS: r_cal.c1   <= i_cfg_data[CAL_W-1:0];
                REG_PRESS_OFF:  r_cal.c2   <= i_cfg_data[CAL_W-1:0];
                REG_SENS_TCO:   r_cal.c3   <= i_cfg_data[CAL_W-1:0];
                REG_OFF_TCO:    r_cal.c4   <= i_cfg_data[CAL_W-1:0];
                REG_REF_TEMP:   r_cal.c5   <= i_cfg_data[CAL_W-1:0];
                REG_TEMP_COEFF: r_cal.c6   <= i_cfg_data[CAL_W-1:0];
                REG_PRESS_LO:   r_cal.p_lo <= i_cfg_data;
                REG_PRESS_HI:   r_cal.p_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cal = r_cal;

endmodule

// ----- sv/pressure_temperature_compensation.sv -----
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Second-order barometric compensation of one raw pressure and one raw
// temperature conversion per beat, with limit check and status.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   i_raw_pressure, i_raw_temperature
//   out       output     o_out_valid / i_out_stall o_status, o_pressure_centi_mbar,
//                                                  o_temperature_centi_c
//   cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// Ten register stages; a beat enters every cycle unless the input is stalled.
// The depth is set by the chain of multipliers: deviation products, squares,
// then the pressure product split into two 24 x 21 partial products.
// Each stage moves on when it is empty or the stage after it moves, so a
// stalled output only holds up the beats behind it and bubbles close up.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [RAW_W-1:0]            i_raw_pressure,
    input  logic [RAW_W-1:0]            i_raw_temperature,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_status,
    output logic [LIMIT_W-1:0]          o_pressure_centi_mbar,
    output logic signed [TEMP_OUT_W-1:0] o_temperature_centi_c,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [LIMIT_W-1:0]          i_cfg_data
);

    localparam int NSTG = 10;
    localparam logic signed [20:0] TEMP_LO = 21'(TEMP_LOW_LIMIT);
    localparam logic signed [20:0] TEMP_HI = 21'(TEMP_HIGH_LIMIT);

    t_ptc_cal cal;

    ptc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cal      (cal)
    );

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_en;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !stg_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    // ------------------------------------------------------------------
    // Stage 0: temperature deviation from reference.
    // ------------------------------------------------------------------
    logic signed [24:0] n_s0_dt;
    logic signed [24:0] r_s0_dt;
    logic [RAW_W-1:0]   r_s0_d1;

    assign n_s0_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, cal.c5, 8'b0});

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            r_s0_dt <= n_s0_dt;
            r_s0_d1 <= i_raw_pressure;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: products of the deviation.
    // ------------------------------------------------------------------
    logic signed [41:0] r_s1_p6;
    logic signed [41:0] r_s1_p4;
    logic signed [41:0] r_s1_p3;
    logic signed [49:0] r_s1_dd;
    logic [RAW_W-1:0]   r_s1_d1;

    always_ff @(posedge i_clk) begin
        if (stg_en[1]) begin
            r_s1_p6 <= r_s0_dt * $signed({1'b0, cal.c6});
            r_s1_p4 <= r_s0_dt * $signed({1'b0, cal.c4});
            r_s1_p3 <= r_s0_dt * $signed({1'b0, cal.c3});
            r_s1_dd <= r_s0_dt * r_s0_dt;
            r_s1_d1 <= r_s0_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first-order temperature, offset and sensitivity.
    // Slicing off the low bits of a signed product is a flooring shift.
    // ------------------------------------------------------------------
    logic signed [18:0] s2_a;
    logic signed [19:0] n_s2_temp1;
    logic signed [19:0] n_s2_b;
    logic signed [37:0] n_s2_off1;
    logic signed [37:0] n_s2_sens1;

    logic signed [18:0] r_s2_a;
    logic signed [19:0] r_s2_b;
    logic signed [19:0] r_s2_temp1;
    logic signed [37:0] r_s2_off1;
    logic signed [37:0] r_s2_sens1;
    logic [17:0]        r_s2_t2;
    logic               r_s2_low2;
    logic               r_s2_low3;
    logic [RAW_W-1:0]   r_s2_d1;

    assign s2_a       = r_s1_p6[41:23];
    assign n_s2_temp1 = $signed({s2_a[18], s2_a}) + 20'sd2000;
    assign n_s2_b     = $signed({s2_a[18], s2_a}) + 20'sd3500;
    assign n_s2_off1  = $signed({5'b0, cal.c2, 17'b0})
                      + $signed({{2{r_s1_p4[41]}}, r_s1_p4[41:6]});
    assign n_s2_sens1 = $signed({6'b0, cal.c1, 16'b0})
                      + $signed({{3{r_s1_p3[41]}}, r_s1_p3[41:7]});

    always_ff @(posedge i_clk) begin
        if (stg_en[2]) begin
            r_s2_a     <= s2_a;
            r_s2_b     <= n_s2_b;
            r_s2_temp1 <= n_s2_temp1;
            r_s2_off1  <= n_s2_off1;
            r_s2_sens1 <= n_s2_sens1;
            r_s2_t2    <= r_s1_dd[48:31];
            // Below 20.00 C the deviation from 2000 is negative.
            r_s2_low2  <= s2_a[18];
            // Below -15.00 C means the deviation is under -3500.
            r_s2_low3  <= (s2_a < -19'sd3500);
            r_s2_d1    <= r_s1_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares for the second-order terms.
    // ------------------------------------------------------------------
    logic signed [37:0] s3_sq_a;
    logic signed [39:0] s3_sq_b;

    logic [34:0]        r_s3_aa;
    logic [36:0]        r_s3_bb;
    logic signed [19:0] r_s3_temp1;
    logic signed [37:0] r_s3_off1;
    logic signed [37:0] r_s3_sens1;
    logic [17:0]        r_s3_t2;
    logic               r_s3_low2;
    logic               r_s3_low3;
    logic [RAW_W-1:0]   r_s3_d1;

    assign s3_sq_a = r_s2_a * r_s2_a;
    assign s3_sq_b = r_s2_b * r_s2_b;

    always_ff @(posedge i_clk) begin
        if (stg_en[3]) begin
            r_s3_aa    <= s3_sq_a[34:0];
            r_s3_bb    <= s3_sq_b[36:0];
            r_s3_temp1 <= r_s2_temp1;
            r_s3_off1  <= r_s2_off1;
            r_s3_sens1 <= r_s2_sens1;
            r_s3_t2    <= r_s2_t2;
            r_s3_low2  <= r_s2_low2;
            r_s3_low3  <= r_s2_low3;
            r_s3_d1    <= r_s2_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: second-order offset and sensitivity corrections.
    // ------------------------------------------------------------------
    logic [40:0] s4_off_a;
    logic [40:0] s4_off_b;
    logic [39:0] s4_sens_b;
    logic [40:0] n_s4_off2;
    logic [39:0] n_s4_sens2;

    logic [40:0]        r_s4_off2;
    logic [39:0]        r_s4_sens2;
    logic signed [19:0] r_s4_temp1;
    logic signed [37:0] r_s4_off1;
    logic signed [37:0] r_s4_sens1;
    logic [17:0]        r_s4_t2;
    logic               r_s4_low2;
    logic [RAW_W-1:0]   r_s4_d1;

    always_comb begin
        s4_off_a  = (41'(r_s3_aa) * 41'd61) >> 4;
        s4_off_b  = r_s3_low3 ? 41'(r_s3_bb) * 41'd15 : '0;
        s4_sens_b = r_s3_low3 ? {r_s3_bb[36:0], 3'b0} : '0;
        n_s4_off2  = r_s3_low2 ? s4_off_a + s4_off_b : '0;
        n_s4_sens2 = r_s3_low2 ? {4'b0, r_s3_aa, 1'b0} + s4_sens_b : '0;
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[4]) begin
            r_s4_off2  <= n_s4_off2;
            r_s4_sens2 <= n_s4_sens2;
            r_s4_temp1 <= r_s3_temp1;
            r_s4_off1  <= r_s3_off1;
            r_s4_sens1 <= r_s3_sens1;
            r_s4_t2    <= r_s3_t2;
            r_s4_low2  <= r_s3_low2;
            r_s4_d1    <= r_s3_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: apply the corrections.
    // ------------------------------------------------------------------
    logic [17:0]        s5_t2;
    logic signed [20:0] r_s5_temp;
    logic signed [42:0] r_s5_off;
    logic signed [41:0] r_s5_sens;
    logic [RAW_W-1:0]   r_s5_d1;

    assign s5_t2 = r_s4_low2 ? r_s4_t2 : '0;

    always_ff @(posedge i_clk) begin
        if (stg_en[5]) begin
            r_s5_temp <= $signed({r_s4_temp1[19], r_s4_temp1}) - $signed({3'b0, s5_t2});
            r_s5_off  <= $signed({{5{r_s4_off1[37]}}, r_s4_off1}) - $signed({2'b0, r_s4_off2});
            r_s5_sens <= $signed({{4{r_s4_sens1[37]}}, r_s4_sens1})
                       - $signed({2'b0, r_s4_sens2});
            r_s5_d1   <= r_s4_d1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: raw pressure times sensitivity, as two partial products.
    // ------------------------------------------------------------------
    logic [20:0]        s6_sens_lo;
    logic signed [20:0] s6_sens_hi;

    logic [44:0]        r_s6_pl;
    logic signed [45:0] r_s6_ph;
    logic signed [20:0] r_s6_temp;
    logic signed [42:0] r_s6_off;

    assign s6_sens_lo = r_s5_sens[20:0];
    assign s6_sens_hi = r_s5_sens[41:21];

    always_ff @(posedge i_clk) begin
        if (stg_en[6]) begin
            r_s6_pl   <= r_s5_d1 * s6_sens_lo;
            r_s6_ph   <= $signed({1'b0, r_s5_d1}) * s6_sens_hi;
            r_s6_temp <= r_s5_temp;
            r_s6_off  <= r_s5_off;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: product shifted down by 21. The high partial product already
    // sits at weight 2^21, and the low one is never negative.
    // ------------------------------------------------------------------
    logic signed [46:0] r_s7_q;
    logic signed [20:0] r_s7_temp;
    logic signed [42:0] r_s7_off;

    always_ff @(posedge i_clk) begin
        if (stg_en[7]) begin
            r_s7_q    <= $signed({r_s6_ph[45], r_s6_ph}) + $signed({23'b0, r_s6_pl[44:21]});
            r_s7_temp <= r_s6_temp;
            r_s7_off  <= r_s6_off;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: subtract offset and scale to 0.01 mbar.
    // ------------------------------------------------------------------
    logic signed [47:0] s8_x;
    logic signed [32:0] r_s8_p;
    logic signed [20:0] r_s8_temp;

    assign s8_x = $signed({r_s7_q[46], r_s7_q}) - $signed({{5{r_s7_off[42]}}, r_s7_off});

    always_ff @(posedge i_clk) begin
        if (stg_en[8]) begin
            r_s8_p    <= s8_x[47:15];
            r_s8_temp <= r_s7_temp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: limit check into the output register. The low check wins.
    // ------------------------------------------------------------------
    logic                         s9_low;
    logic                         s9_high;
    logic [1:0]                   n_status;
    logic [1:0]                   r_status;
    logic [LIMIT_W-1:0]           r_press;
    logic signed [TEMP_OUT_W-1:0] r_temp;

    always_comb begin
        s9_low  = (r_s8_p < $signed({15'b0, cal.p_lo})) || (r_s8_temp < TEMP_LO);
        s9_high = (r_s8_p > $signed({15'b0, cal.p_hi})) || (r_s8_temp > TEMP_HI);
        if (s9_low) begin
            n_status = STAT_LOW;
        end else if (s9_high) begin
            n_status = STAT_HIGH;
        end else begin
            n_status = STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[9]) begin
            r_status <= n_status;
            if (n_status == STAT_OK) begin
                r_press <= r_s8_p[LIMIT_W-1:0];
                r_temp  <= r_s8_temp[TEMP_OUT_W-1:0];
            end else begin
                r_press <= '0;
                r_temp  <= '0;
            end
        end
    end

    assign o_status              = r_status;
    assign o_pressure_centi_mbar = r_press;
    assign o_temperature_centi_c = r_temp;

endmodule

// ----- sv/ptc_checker.sv -----
// ----------------------------------------------------------------------------
// ptc_assertions
// Port-level checks of the compensation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_assertions
    import ptc_pkg::*;
(
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [1:0]                   o_status,
    input logic [LIMIT_W-1:0]           o_pressure_centi_mbar,
    input logic signed [TEMP_OUT_W-1:0] o_temperature_centi_c
);

    // A beat that fails the limits carries zeroed values.
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_OK) |->
            (o_pressure_centi_mbar == '0 && o_temperature_centi_c == '0))
        else $error("failed beat carries nonzero values");

    // A passing beat has a temperature inside the fixed limits.
    a_temp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_OK) |->
            (o_temperature_centi_c >= 15'(TEMP_LOW_LIMIT)
             && o_temperature_centi_c <= 15'(TEMP_HIGH_LIMIT)))
        else $error("passing beat has temperature out of range");

    // With the output register empty, nothing can back up to the input.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled while output register is empty");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_pressure_centi_mbar)
             && $stable(o_temperature_centi_c)))
        else $error("stalled output beat changed");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind pressure_temperature_compensation ptc_assertions u_ptc_assertions (.*);
